### src/maf_pkg.sv
// shared widths, register indexes and unit handshake types for the attitude filter
`timescale 1ns / 1ps

package maf_pkg;

    localparam int RATE_W      = 24;
    localparam int ACCEL_W     = 16;
    localparam int QUAT_W      = 32;
    localparam int S_TDATA_W   = 120;
    localparam int M_TDATA_W   = 128;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int PGAIN_W     = 23;
    localparam int IGAIN_W     = 23;
    localparam int PERIOD_W    = 30;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 2'd2;

    localparam int RD_NUM_W    = 64;
    localparam int RD_DEN_W    = 32;

    typedef struct packed {
        logic start;
        logic is_sqrt;
    } rd_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rd_stat_t;

endpackage

### src/maf_root_div.sv
// bit-serial unsigned divider and integer square root sharing one subtractor
`timescale 1ns / 1ps

module maf_root_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  maf_pkg::rd_req_t              req,
    input  logic [maf_pkg::RD_NUM_W-1:0]  num,
    input  logic [maf_pkg::RD_DEN_W-1:0]  den,
    output maf_pkg::rd_stat_t             stat,
    output logic [maf_pkg::RD_NUM_W-1:0]  result
);
    import maf_pkg::*;

    localparam int REM_W = RD_DEN_W + 2;
    localparam int CNT_W = $clog2(RD_NUM_W);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 sqrt_reg, sqrt_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [RD_NUM_W-1:0]  src_reg, src_next;
    logic [RD_NUM_W-1:0]  res_reg, res_next;
    logic [RD_DEN_W-1:0]  den_reg, den_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [REM_W+1:0]     shift_rem;
    logic [REM_W+1:0]     trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sqrt_next = sqrt_reg;
        cnt_next  = cnt_reg;
        src_next  = src_reg;
        res_next  = res_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        shift_rem = '0;
        trial     = '0;
        if (busy_reg) begin
            if (sqrt_reg) begin
                shift_rem = {rem_reg, src_reg[RD_NUM_W-1 -: 2]};
                trial     = (REM_W+2)'({res_reg[RD_DEN_W-1:0], 2'b01});
                src_next  = src_reg << 2;
            end else begin
                shift_rem = (REM_W+2)'({rem_reg, src_reg[RD_NUM_W-1]});
                trial     = (REM_W+2)'(den_reg);
                src_next  = src_reg << 1;
            end
            if (shift_rem >= trial) begin
                rem_next = REM_W'(shift_rem - trial);
                res_next = {res_reg[RD_NUM_W-2:0], 1'b1};
            end else begin
                rem_next = REM_W'(shift_rem);
                res_next = {res_reg[RD_NUM_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            sqrt_next = req.is_sqrt;
            cnt_next  = req.is_sqrt ? CNT_W'(RD_NUM_W / 2 - 1) : CNT_W'(RD_NUM_W - 1);
            src_next  = num;
            den_next  = den;
            rem_next  = '0;
            res_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        sqrt_reg <= sqrt_next;
        cnt_reg  <= cnt_next;
        src_reg  <= src_next;
        res_reg  <= res_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
    end

    assign stat   = '{busy: busy_reg, done: done_reg};
    assign result = res_reg;

endmodule

### src/mahony_attitude_filter.sv
// mahony imu attitude filter: sequencer, shared multiplier and state registers
`timescale 1ns / 1ps

// throughput: one request at a time; s_tready is high only while the sequencer is idle
// the time is set by the bit-serial divider (up to seven quotients) and the square root (up to two roots)
// plus the MUL and WB states of each shared multiply
// reset: quaternion to identity, integral terms to zero, gains and period to defaults
module mahony_attitude_filter (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // rate_x, rate_y, rate_z, accel_x, accel_y, accel_z
    input  logic [maf_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // quat_w, quat_x, quat_y, quat_z
    output logic [maf_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [maf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [maf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import maf_pkg::*;

    localparam int MUL_W  = 36;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 66;
    localparam int WK_W   = 34;
    localparam int TERM_W = 28;
    localparam int MAG_W  = QUAT_W + 1;

    localparam logic signed [PROD_W-1:0] HALF30   = PROD_W'(1) << 29;
    localparam logic signed [PROD_W-1:0] HALF17   = PROD_W'(1) << 16;
    localparam logic signed [ACC_W-1:0]  QHALF    = ACC_W'(1) << 29;
    localparam logic signed [ACC_W-1:0]  SAT_HI   = (ACC_W'(1) << (QUAT_W - 1)) - 1;
    localparam logic signed [QUAT_W-1:0] ONE_Q30  = QUAT_W'(1) << 30;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_WB, ST_ROOT, ST_ROOT_WAIT, ST_DIV, ST_DIV_WAIT, ST_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_ASQ, OP_V0A, OP_V0B, OP_V1A, OP_V1B, OP_V2A, OP_V2B,
        OP_E0A, OP_E0B, OP_E1A, OP_E1B, OP_E2A, OP_E2B,
        OP_KI, OP_KT, OP_KP, OP_H,
        OP_N0A, OP_N0B, OP_N0C, OP_N1A, OP_N1B, OP_N1C,
        OP_N2A, OP_N2B, OP_N2C, OP_N3A, OP_N3B, OP_N3C, OP_SQ
    } op_t;

    function automatic logic signed [QUAT_W-1:0] sat32(input logic signed [ACC_W-1:0] x,
                                                      input logic sym);
        logic signed [ACC_W-1:0] lo;
        lo = sym ? -SAT_HI : -SAT_HI - 1;
        if (x > SAT_HI) begin
            return QUAT_W'(SAT_HI);
        end else if (x < lo) begin
            return QUAT_W'(lo);
        end
        return QUAT_W'(x);
    endfunction

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic [1:0] lane_reg, lane_next;
    logic   quat_phase_reg, quat_phase_next;
    logic   m_valid_reg, m_valid_next;

    logic [PGAIN_W-1:0]  kp_reg;
    logic [IGAIN_W-1:0]  ki_reg;
    logic [PERIOD_W-1:0] dt_reg;

    logic signed [QUAT_W-1:0]  q_reg[4], q_next[4];
    logic signed [QUAT_W-1:0]  integ_reg[3], integ_next[3];
    logic signed [QUAT_W-1:0]  h_reg[3], h_next[3];
    logic signed [QUAT_W-1:0]  n_reg[4], n_next[4];
    logic signed [WK_W-1:0]    g_reg[3], g_next[3];
    logic signed [WK_W-1:0]    u_reg[3], u_next[3];
    logic signed [WK_W-1:0]    v_reg[3], v_next[3];
    logic signed [WK_W-1:0]    e_reg[3], e_next[3];
    logic signed [ACCEL_W-1:0] a_reg[3], a_next[3];
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [TERM_W-1:0]  t_reg, t_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [RD_DEN_W-1:0]       nrm_reg, nrm_next;
    logic [M_TDATA_W-1:0]      out_reg, out_next;

    logic signed [MUL_W-1:0]   ma, mb;
    logic signed [PROD_W-1:0]  rnd30_full, rnd17_full;
    logic signed [ACC_W-1:0]   r30, r17, rp;
    logic signed [QUAT_W-1:0]  isum;

    rd_req_t                   rd_req;
    rd_stat_t                  rd_stat;
    logic [RD_NUM_W-1:0]       rd_num, rd_result;
    logic                      div_neg;
    logic signed [MAG_W-1:0]   div_src;
    logic [MAG_W-1:0]          div_mag;
    logic signed [WK_W-1:0]    quo_w;
    logic signed [QUAT_W-1:0]  quo_q;

    maf_root_div u_root_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rd_req),
        .num     (rd_num),
        .den     (nrm_reg),
        .stat    (rd_stat),
        .result  (rd_result)
    );

    // operand select for the shared multiplier
    always_comb begin
        ma = '0;
        mb = '0;
        unique case (op_reg)
            OP_ASQ: begin
                ma = MUL_W'(a_reg[lane_reg]);
                mb = MUL_W'(a_reg[lane_reg]);
            end
            OP_V0A: begin ma = MUL_W'(q_reg[1]); mb = MUL_W'(q_reg[3]); end
            OP_V0B: begin ma = MUL_W'(q_reg[0]); mb = MUL_W'(q_reg[2]); end
            OP_V1A: begin ma = MUL_W'(q_reg[0]); mb = MUL_W'(q_reg[1]); end
            OP_V1B: begin ma = MUL_W'(q_reg[2]); mb = MUL_W'(q_reg[3]); end
            OP_V2A: begin ma = MUL_W'(q_reg[0]); mb = MUL_W'(q_reg[0]); end
            OP_V2B: begin ma = MUL_W'(q_reg[3]); mb = MUL_W'(q_reg[3]); end
            OP_E0A: begin ma = MUL_W'(u_reg[1]); mb = MUL_W'(v_reg[2]); end
            OP_E0B: begin ma = MUL_W'(u_reg[2]); mb = MUL_W'(v_reg[1]); end
            OP_E1A: begin ma = MUL_W'(u_reg[2]); mb = MUL_W'(v_reg[0]); end
            OP_E1B: begin ma = MUL_W'(u_reg[0]); mb = MUL_W'(v_reg[2]); end
            OP_E2A: begin ma = MUL_W'(u_reg[0]); mb = MUL_W'(v_reg[1]); end
            OP_E2B: begin ma = MUL_W'(u_reg[1]); mb = MUL_W'(v_reg[0]); end
            OP_KI: begin
                ma = MUL_W'(ki_reg);
                mb = MUL_W'(e_reg[lane_reg]);
            end
            OP_KT: begin
                ma = MUL_W'(t_reg);
                mb = MUL_W'(dt_reg);
            end
            OP_KP: begin
                ma = MUL_W'(kp_reg);
                mb = MUL_W'(e_reg[lane_reg]);
            end
            OP_H: begin
                ma = MUL_W'(g_reg[lane_reg]);
                mb = MUL_W'(dt_reg);
            end
            OP_N0A: begin ma = MUL_W'(q_reg[1]); mb = MUL_W'(h_reg[0]); end
            OP_N0B: begin ma = MUL_W'(q_reg[2]); mb = MUL_W'(h_reg[1]); end
            OP_N0C: begin ma = MUL_W'(q_reg[3]); mb = MUL_W'(h_reg[2]); end
            OP_N1A: begin ma = MUL_W'(q_reg[0]); mb = MUL_W'(h_reg[0]); end
            OP_N1B: begin ma = MUL_W'(q_reg[2]); mb = MUL_W'(h_reg[2]); end
            OP_N1C: begin ma = MUL_W'(q_reg[3]); mb = MUL_W'(h_reg[1]); end
            OP_N2A: begin ma = MUL_W'(q_reg[0]); mb = MUL_W'(h_reg[1]); end
            OP_N2B: begin ma = MUL_W'(q_reg[1]); mb = MUL_W'(h_reg[2]); end
            OP_N2C: begin ma = MUL_W'(q_reg[3]); mb = MUL_W'(h_reg[0]); end
            OP_N3A: begin ma = MUL_W'(q_reg[0]); mb = MUL_W'(h_reg[2]); end
            OP_N3B: begin ma = MUL_W'(q_reg[1]); mb = MUL_W'(h_reg[1]); end
            OP_N3C: begin ma = MUL_W'(q_reg[2]); mb = MUL_W'(h_reg[0]); end
            OP_SQ: begin
                ma = MUL_W'(n_reg[lane_reg]);
                mb = MUL_W'(n_reg[lane_reg]);
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    // round to nearest, ties up
    always_comb begin
        rnd30_full = (prod_reg + HALF30) >>> 30;
        rnd17_full = (prod_reg + HALF17) >>> 17;
        r30        = ACC_W'(rnd30_full);
        r17        = ACC_W'(rnd17_full);
        rp         = ACC_W'(prod_reg);
        isum       = sat32(ACC_W'(integ_reg[lane_reg]) + r30, 1'b0);
    end

    // divider operand: magnitude shifted up, sign applied after; in ST_ROOT the root operand comes from acc_reg
    always_comb begin
        if (quat_phase_reg) begin
            div_src = MAG_W'(n_reg[lane_reg]);
        end else begin
            div_src = MAG_W'(a_reg[lane_reg]);
        end
        div_neg = div_src[MAG_W-1];
        div_mag = div_neg ? MAG_W'(-div_src) : MAG_W'(div_src);
        if (quat_phase_reg) begin
            rd_num = RD_NUM_W'(div_mag) << 30;
        end else begin
            rd_num = RD_NUM_W'(div_mag) << 46;
        end
        quo_w   = WK_W'(rd_result);
        quo_q   = QUAT_W'(rd_result);
        if (state_reg == ST_ROOT) begin
            rd_num = quat_phase_reg ? RD_NUM_W'(acc_reg) : {acc_reg[31:0], 32'b0};
        end
    end

    always_comb begin
        rd_req = '{start: 1'b0, is_sqrt: 1'b0};
        if (state_reg == ST_ROOT) begin
            rd_req = '{start: 1'b1, is_sqrt: 1'b1};
        end else if (state_reg == ST_DIV) begin
            rd_req = '{start: 1'b1, is_sqrt: 1'b0};
        end
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        lane_next       = lane_reg;
        quat_phase_next = quat_phase_reg;
        m_valid_next    = m_valid_reg & ~m_tready;
        q_next          = q_reg;
        integ_next      = integ_reg;
        h_next          = h_reg;
        n_next          = n_reg;
        g_next          = g_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        e_next          = e_reg;
        a_next          = a_reg;
        acc_next        = acc_reg;
        t_next          = t_reg;
        nrm_next        = nrm_reg;
        out_next        = out_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    g_next[0] = WK_W'($signed(s_tdata[23:0]));
                    g_next[1] = WK_W'($signed(s_tdata[47:24]));
                    g_next[2] = WK_W'($signed(s_tdata[71:48]));
                    a_next[0] = $signed(s_tdata[87:72]);
                    a_next[1] = $signed(s_tdata[103:88]);
                    a_next[2] = $signed(s_tdata[119:104]);
                    lane_next       = 2'd0;
                    quat_phase_next = 1'b0;
                    op_next         = (s_tdata[119:72] != '0) ? OP_ASQ : OP_H;
                    state_next      = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_WB;
            end
            ST_WB: begin
                state_next = ST_MUL;
                unique case (op_reg)
                    OP_ASQ: begin
                        acc_next = ((lane_reg == 2'd0) ? '0 : acc_reg) + rp;
                        if (lane_reg == 2'd2) begin
                            state_next = ST_ROOT;
                        end else begin
                            lane_next = lane_reg + 2'd1;
                        end
                    end
                    OP_V0A: begin acc_next = r30; op_next = OP_V0B; end
                    OP_V0B: begin v_next[0] = WK_W'(acc_reg - r30); op_next = OP_V1A; end
                    OP_V1A: begin acc_next = r30; op_next = OP_V1B; end
                    OP_V1B: begin v_next[1] = WK_W'(acc_reg + r30); op_next = OP_V2A; end
                    OP_V2A: begin acc_next = r30 - QHALF; op_next = OP_V2B; end
                    OP_V2B: begin v_next[2] = WK_W'(acc_reg + r30); op_next = OP_E0A; end
                    OP_E0A: begin acc_next = r30; op_next = OP_E0B; end
                    OP_E0B: begin e_next[0] = WK_W'(acc_reg - r30); op_next = OP_E1A; end
                    OP_E1A: begin acc_next = r30; op_next = OP_E1B; end
                    OP_E1B: begin e_next[1] = WK_W'(acc_reg - r30); op_next = OP_E2A; end
                    OP_E2A: begin acc_next = r30; op_next = OP_E2B; end
                    OP_E2B: begin
                        e_next[2] = WK_W'(acc_reg - r30);
                        lane_next = 2'd0;
                        op_next   = (ki_reg != '0) ? OP_KI : OP_KP;
                    end
                    OP_KI: begin
                        t_next  = TERM_W'(r30);
                        op_next = OP_KT;
                    end
                    OP_KT: begin
                        integ_next[lane_reg] = isum;
                        g_next[lane_reg]     = g_reg[lane_reg] + WK_W'(isum);
                        op_next              = OP_KP;
                    end
                    OP_KP: begin
                        g_next[lane_reg] = g_reg[lane_reg] + WK_W'(r30);
                        if (ki_reg == '0) begin
                            integ_next[lane_reg] = '0;
                        end
                        if (lane_reg == 2'd2) begin
                            lane_next = 2'd0;
                            op_next   = OP_H;
                        end else begin
                            lane_next = lane_reg + 2'd1;
                            op_next   = (ki_reg != '0) ? OP_KI : OP_KP;
                        end
                    end
                    OP_H: begin
                        h_next[lane_reg] = sat32(r17, 1'b1);
                        if (lane_reg == 2'd2) begin
                            lane_next = 2'd0;
                            op_next   = OP_N0A;
                        end else begin
                            lane_next = lane_reg + 2'd1;
                        end
                    end
                    OP_N0A: begin acc_next = ACC_W'(q_reg[0]) - r30; op_next = OP_N0B; end
                    OP_N0B: begin acc_next = acc_reg - r30; op_next = OP_N0C; end
                    OP_N0C: begin n_next[0] = sat32(acc_reg - r30, 1'b1); op_next = OP_N1A; end
                    OP_N1A: begin acc_next = ACC_W'(q_reg[1]) + r30; op_next = OP_N1B; end
                    OP_N1B: begin acc_next = acc_reg + r30; op_next = OP_N1C; end
                    OP_N1C: begin n_next[1] = sat32(acc_reg - r30, 1'b1); op_next = OP_N2A; end
                    OP_N2A: begin acc_next = ACC_W'(q_reg[2]) + r30; op_next = OP_N2B; end
                    OP_N2B: begin acc_next = acc_reg - r30; op_next = OP_N2C; end
                    OP_N2C: begin n_next[2] = sat32(acc_reg + r30, 1'b1); op_next = OP_N3A; end
                    OP_N3A: begin acc_next = ACC_W'(q_reg[3]) + r30; op_next = OP_N3B; end
                    OP_N3B: begin acc_next = acc_reg + r30; op_next = OP_N3C; end
                    OP_N3C: begin
                        n_next[3] = sat32(acc_reg - r30, 1'b1);
                        lane_next = 2'd0;
                        op_next   = OP_SQ;
                    end
                    OP_SQ: begin
                        acc_next = ((lane_reg == 2'd0) ? '0 : acc_reg) + rp;
                        if (lane_reg == 2'd3) begin
                            quat_phase_next = 1'b1;
                            state_next      = ST_ROOT;
                        end else begin
                            lane_next = lane_reg + 2'd1;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_ROOT: begin
                state_next = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT: begin
                if (rd_stat.done) begin
                    nrm_next  = rd_result[RD_DEN_W-1:0];
                    lane_next = 2'd0;
                    if (quat_phase_reg && (rd_result[RD_DEN_W-1:0] == '0)) begin
                        q_next[0]  = ONE_Q30;
                        q_next[1]  = '0;
                        q_next[2]  = '0;
                        q_next[3]  = '0;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (rd_stat.done) begin
                    if (quat_phase_reg) begin
                        q_next[lane_reg] = div_neg ? -quo_q : quo_q;
                        if (lane_reg == 2'd3) begin
                            state_next = ST_OUT;
                        end else begin
                            lane_next  = lane_reg + 2'd1;
                            state_next = ST_DIV;
                        end
                    end else begin
                        u_next[lane_reg] = div_neg ? -quo_w : quo_w;
                        if (lane_reg == 2'd2) begin
                            lane_next  = 2'd0;
                            op_next    = OP_V0A;
                            state_next = ST_MUL;
                        end else begin
                            lane_next  = lane_reg + 2'd1;
                            state_next = ST_DIV;
                        end
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    out_next     = {q_reg[3], q_reg[2], q_reg[1], q_reg[0]};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_ASQ;
            lane_reg       <= 2'd0;
            quat_phase_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            kp_reg         <= PGAIN_W'(65536);
            ki_reg         <= IGAIN_W'(66);
            dt_reg         <= PERIOD_W'(5368709);
            q_reg[0]       <= ONE_Q30;
            q_reg[1]       <= '0;
            q_reg[2]       <= '0;
            q_reg[3]       <= '0;
            integ_reg[0]   <= '0;
            integ_reg[1]   <= '0;
            integ_reg[2]   <= '0;
        end else begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            lane_reg       <= lane_next;
            quat_phase_reg <= quat_phase_next;
            m_valid_reg    <= m_valid_next;
            out_reg        <= out_next;
            q_reg          <= q_next;
            integ_reg      <= integ_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_PROP_GAIN: kp_reg <= cfg_data[PGAIN_W-1:0];
                    REG_INT_GAIN:  ki_reg <= cfg_data[IGAIN_W-1:0];
                    REG_PERIOD:    dt_reg <= cfg_data[PERIOD_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= ma * mb;
        h_reg    <= h_next;
        n_reg    <= n_next;
        g_reg    <= g_next;
        u_reg    <= u_next;
        v_reg    <= v_next;
        e_reg    <= e_next;
        a_reg    <= a_next;
        acc_reg  <= acc_next;
        t_reg    <= t_next;
        nrm_reg  <= nrm_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = out_reg;
    assign cfg_ready = 1'b1;

endmodule
